>>> rtl/uvwc_pkg.sv
// uvwc_pkg: types, status codes and the whitespace table for the utf-8 validator
// with whitespace collapsing. No dependencies; used by the top level, the checker and the testbench.
package uvwc_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOO_LONG = 3'd1,
      ST_BAD_UTF8 = 3'd2,
      ST_BAD_TEXT = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   localparam int unsigned BURST_MAX   = 5;   // optional space plus up to four code bytes
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned BURST_IDX_W = $clog2(BURST_MAX);
   localparam int unsigned BURST_CNT_W = $clog2(BURST_MAX + 1);

   localparam logic [7:0]  ASCII_SPACE = 8'h20;
   localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
   localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
   localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
   localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
   localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
   localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] SURR_MIN    = 21'h00D800;
   localparam logic [20:0] SURR_MAX    = 21'h00DFFF;
   localparam logic [20:0] C1_MIN      = 21'h00007F;
   localparam logic [20:0] C1_MAX      = 21'h00009F;

   // one queue entry: every result caused by one accepted item
   typedef struct packed {
      logic                      kind;
      status_type                status;
      logic [7:0]                length;
      logic [BURST_CNT_W-1:0]    count;
      logic [BURST_MAX-1:0][7:0] data;
   } burst_type;

   function automatic logic is_white(input logic [20:0] cp);
      return (cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h20 || cp == 21'h85 ||
             cp == 21'hA0 || cp == 21'h1680 || (cp >= 21'h2000 && cp <= 21'h200A) ||
             cp == 21'h2028 || cp == 21'h2029 || cp == 21'h202F ||
             cp == 21'h205F || cp == 21'h3000;
   endfunction

endpackage

>>> rtl/utf8_validate_whitespace_collapse_unit.sv
// utf8_validate_whitespace_collapse_unit: strict utf-8 decoder, control check and
// whitespace collapsing, with a small queue of result bursts. Depends on uvwc_pkg.
//
// Usage:
//   req channel: one text byte per item in req_tdata, a zero byte ends the text.
//   rsp channel: normalised data bytes (tuser 0) and one status item (tuser 1)
//   per text; tlast marks the final result caused by one input item.
//   Decode, checks and state update happen in the cycle an item is accepted; its
//   results (none, one status item, or up to five bytes: a space then up to four
//   code bytes) are written as one burst into a four-entry queue.
//   Results are registered: an item's burst enters the queue and is sent from its head.
//   Throughput: one item per cycle while the queue has room; the rsp side sends
//   one result per cycle while rsp_tready is high, so multi-result items drain at that rate.
//   req_tready drops only when all four queue entries are occupied.
//   Reset (synchronous, active high) clears the decoder state and empties the
//   queue. A stalled receiver holds the head result steady; the queue then fills
//   and backpressures the request side. No clearing pass is needed after reset.
module utf8_validate_whitespace_collapse_unit
   import uvwc_pkg::*;
#(
   parameter int unsigned SOURCE_CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, [18:11] norm_length
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int unsigned CNT_W = $clog2(SOURCE_CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(SOURCE_CAPACITY);

   // decoder state
   logic [CNT_W-1:0]  in_cnt_ff, in_cnt_in;
   logic [7:0]        out_cnt_ff, out_cnt_in;
   logic [20:0]       partial_ff, partial_in;
   logic [3:0][7:0]   seq_ff, seq_in;
   logic [1:0]        cont_left_ff, cont_left_in;
   logic [1:0]        seq_len_ff, seq_len_in;
   logic              space_ff, space_in;
   status_type        first_err_ff, first_err_in;

   // queue
   burst_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, tail_ff;
   logic [QUEUE_CNT_W-1:0] qcnt_ff;
   logic [BURST_IDX_W-1:0] idx_ff;

   logic        req_accept, rsp_accept, pop;
   logic        push;
   burst_type   burst;
   logic        do_finish;
   logic [20:0] fin_cp;
   logic [2:0]  fin_n;
   logic [20:0] combined;
   logic [7:0]  in_byte;
   logic        bad_value;
   logic        white, ctrl;
   logic [8:0]  out_sum;
   logic [2:0]  emit_n;
   logic [1:0]  wr_slot;
   burst_type   head;

   assign in_byte    = req_tdata;
   assign req_tready = (qcnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign combined   = {partial_ff[14:0], in_byte[5:0]};
   assign wr_slot    = seq_len_ff + 2'd1 - cont_left_ff;
   assign bad_value  = (seq_len_ff == 2'd1 && combined < 21'h80) ||
                       (seq_len_ff == 2'd2 && combined < 21'h800) ||
                       (seq_len_ff == 2'd3 && combined < 21'h10000) ||
                       (combined >= SURR_MIN && combined <= SURR_MAX) ||
                       combined > CP_MAX;
   assign white = is_white(fin_cp);
   assign ctrl  = fin_cp < 21'h20 || (fin_cp >= C1_MIN && fin_cp <= C1_MAX);

   always_comb begin
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      partial_in   = partial_ff;
      seq_in       = seq_ff;
      cont_left_in = cont_left_ff;
      seq_len_in   = seq_len_ff;
      space_in     = space_ff;
      first_err_in = first_err_ff;
      push         = 1'b0;
      burst        = '0;
      do_finish    = 1'b0;
      fin_cp       = '0;
      fin_n        = '0;
      emit_n       = '0;
      out_sum      = '0;

      if (req_accept) begin
         if (in_byte == 8'h00) begin
            push         = 1'b1;
            burst.kind   = 1'b1;
            burst.count  = BURST_CNT_W'(1);
            burst.length = out_cnt_ff;
            if (first_err_ff != ST_OK)      burst.status = first_err_ff;
            else if (cont_left_ff != 2'd0)  burst.status = ST_BAD_UTF8;
            else if (out_cnt_ff == 8'd0)    burst.status = ST_EMPTY;
            else                            burst.status = ST_OK;
            in_cnt_in    = '0;
            out_cnt_in   = '0;
            partial_in   = '0;
            cont_left_in = '0;
            seq_len_in   = '0;
            space_in     = 1'b0;
            first_err_in = ST_OK;
         end else begin
            if (in_cnt_ff < CAP) in_cnt_in = in_cnt_ff + CNT_W'(1);
            if (in_cnt_in == CAP) begin
               first_err_in = ST_TOO_LONG;
            end else if (first_err_ff != ST_OK) begin
               first_err_in = first_err_ff;
            end else if (cont_left_ff == 2'd0) begin
               seq_in[0] = in_byte;
               if (in_byte < 8'h80) begin
                  do_finish = 1'b1;
                  fin_cp    = {13'd0, in_byte};
                  fin_n     = 3'd1;
               end else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX) begin
                  partial_in = {16'd0, in_byte[4:0]};
                  cont_left_in = 2'd1;
                  seq_len_in   = 2'd1;
               end else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX) begin
                  partial_in = {17'd0, in_byte[3:0]};
                  cont_left_in = 2'd2;
                  seq_len_in   = 2'd2;
               end else if (in_byte >= LEAD4_MIN && in_byte <= LEAD4_MAX) begin
                  partial_in = {18'd0, in_byte[2:0]};
                  cont_left_in = 2'd3;
                  seq_len_in   = 2'd3;
               end else begin
                  first_err_in = ST_BAD_UTF8;
               end
            end else if (in_byte[7:6] != 2'b10) begin
               first_err_in = ST_BAD_UTF8;
               cont_left_in = 2'd0;
            end else begin
               seq_in[wr_slot] = in_byte;
               partial_in      = combined;
               cont_left_in    = cont_left_ff - 2'd1;
               if (cont_left_ff == 2'd1) begin
                  if (bad_value) begin
                     first_err_in = ST_BAD_UTF8;
                  end else begin
                     do_finish = 1'b1;
                     fin_cp    = combined;
                     fin_n     = {1'b0, seq_len_ff} + 3'd1;
                  end
               end
            end
         end
      end

      // a completed codepoint: reject controls, collapse whitespace, else emit
      if (do_finish) begin
         if (ctrl && !white) begin
            first_err_in = ST_BAD_TEXT;
         end else if (white) begin
            space_in = (out_cnt_ff != 8'd0);
         end else begin
            push        = 1'b1;
            emit_n      = fin_n + {2'd0, space_ff};
            burst.count = BURST_CNT_W'(emit_n);
            if (space_ff) burst.data = {seq_in, ASCII_SPACE};
            else          burst.data = {8'h00, seq_in};
            out_sum     = {1'b0, out_cnt_ff} + {6'd0, emit_n};
            out_cnt_in  = out_sum[8] ? 8'hFF : out_sum[7:0];
            space_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         partial_ff   <= '0;
         cont_left_ff <= '0;
         seq_len_ff   <= '0;
         space_ff     <= 1'b0;
         first_err_ff <= ST_OK;
      end else begin
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         partial_ff   <= partial_in;
         cont_left_ff <= cont_left_in;
         seq_len_ff   <= seq_len_in;
         space_ff     <= space_in;
         first_err_ff <= first_err_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      if (push) queue_ff[tail_ff] <= burst;
   end

   // output side walks the head burst one item at a time
   assign head       = queue_ff[head_ff];
   assign rsp_tvalid = (qcnt_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign rsp_tlast  = (BURST_CNT_W'(idx_ff) + BURST_CNT_W'(1)) == head.count;
   assign pop        = rsp_accept && rsp_tlast;
   assign rsp_tuser  = head.kind;
   assign rsp_tdata  = {5'd0, head.length, head.status, head.data[idx_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         qcnt_ff <= '0;
         idx_ff  <= '0;
      end else begin
         if (push) tail_ff <= tail_ff + QUEUE_PTR_W'(1);
         if (pop) begin
            head_ff <= head_ff + QUEUE_PTR_W'(1);
            idx_ff  <= '0;
         end else if (rsp_accept) begin
            idx_ff  <= idx_ff + BURST_IDX_W'(1);
         end
         qcnt_ff <= qcnt_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue over capacity");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("status item not marked last");

   a_text_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tdata == 8'h00 |=>
         cont_left_ff == 2'd0 && out_cnt_ff == 8'd0 && first_err_ff == ST_OK)
      else $error("state not cleared after terminator");

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (BURST_CNT_W'(idx_ff) < head.count))
      else $error("item index beyond burst");

endmodule

>>> sim/utf8_collapse_checker.sv
// utf8_collapse_checker: watches both channels of the utf-8 validator, predicts the
// normalised bytes and status items from the accepted text bytes and compares them.
// Depends on uvwc_pkg for the status codes and byte-range constants.
module utf8_collapse_checker
   import uvwc_pkg::*;
#(
   parameter int unsigned SOURCE_CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, [18:11] norm_length
   input  logic        rsp_tuser,   // result_kind
   input  logic        rsp_tlast,   // last_of_run
   output int unsigned fail_count,
   output int unsigned open_count
);

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      status_type st;
      logic [7:0] length;
      logic       last;
   } norm_item_type;

   norm_item_type awaited_items[$];
   norm_item_type burst[6];
   int            burst_n;
   int unsigned   mismatches = 0;

   // decoder state of the text in progress
   int unsigned   in_cnt;
   logic [7:0]    out_cnt;
   logic [20:0]   acc;
   logic [7:0]    seq[4];
   logic [1:0]    cont_left;
   logic [1:0]    seq_len;
   logic          space_due;
   status_type    first_err;

   function automatic void clear_text();
      in_cnt    = 0;
      out_cnt   = 8'd0;
      acc       = 21'd0;
      cont_left = 2'd0;
      seq_len   = 2'd0;
      space_due = 1'b0;
      first_err = ST_OK;
   endfunction

   function automatic logic white_cp(input logic [20:0] cp);
      if (cp >= 21'h2000 && cp <= 21'h200A) return 1'b1;
      case (cp)
         21'h09, 21'h0A, 21'h0B, 21'h0C, 21'h0D, 21'h20, 21'h85, 21'hA0, 21'h1680,
         21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      burst[burst_n] = '{1'b0, b, ST_OK, 8'd0, 1'b0};
      burst_n++;
      if (out_cnt != 8'd255) out_cnt++;
   endfunction

   // a complete, well-formed codepoint: control check, then collapse or emit
   function automatic void finish_cp(input logic [20:0] cp, input int n);
      logic w;
      w = white_cp(cp);
      if ((cp < 21'h20 || (cp >= C1_MIN && cp <= C1_MAX)) && !w) begin
         first_err = ST_BAD_TEXT;
      end else if (w) begin
         space_due = (out_cnt != 8'd0);
      end else begin
         if (space_due) add_byte(ASCII_SPACE);
         for (int i = 0; i < n; i++) add_byte(seq[i]);
         space_due = 1'b0;
      end
   endfunction

   function automatic void normalise_byte(input logic [7:0] b);
      status_type st;
      logic [1:0] slot;
      burst_n = 0;
      if (b == 8'h00) begin
         if (first_err != ST_OK) st = first_err;
         else if (cont_left != 2'd0) st = ST_BAD_UTF8;
         else if (out_cnt == 8'd0) st = ST_EMPTY;
         else st = ST_OK;
         burst[0] = '{1'b1, 8'h00, st, out_cnt, 1'b0};
         burst_n  = 1;
         clear_text();
      end else begin
         if (in_cnt < SOURCE_CAPACITY) in_cnt++;
         if (in_cnt >= SOURCE_CAPACITY) begin
            first_err = ST_TOO_LONG;
         end else if (first_err == ST_OK) begin
            if (cont_left == 2'd0) begin
               seq[0] = b;
               if (b < 8'h80) begin
                  finish_cp({13'd0, b}, 1);
               end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                  acc = {16'd0, b[4:0]};
                  cont_left = 2'd1;
                  seq_len = 2'd1;
               end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                  acc = {17'd0, b[3:0]};
                  cont_left = 2'd2;
                  seq_len = 2'd2;
               end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                  acc = {18'd0, b[2:0]};
                  cont_left = 2'd3;
                  seq_len = 2'd3;
               end else begin
                  first_err = ST_BAD_UTF8;
               end
            end else if (b[7:6] != 2'b10) begin
               first_err = ST_BAD_UTF8;
               cont_left = 2'd0;
            end else begin
               slot = seq_len + 2'd1 - cont_left;
               seq[slot] = b;
               acc = {acc[14:0], b[5:0]};
               cont_left = cont_left - 2'd1;
               if (cont_left == 2'd0) begin
                  // overlong, surrogate or beyond the last codepoint
                  if ((seq_len == 2'd1 && acc < 21'h80) ||
                      (seq_len == 2'd2 && acc < 21'h800) ||
                      (seq_len == 2'd3 && acc < 21'h10000) ||
                      (acc >= SURR_MIN && acc <= SURR_MAX) || acc > CP_MAX) begin
                     first_err = ST_BAD_UTF8;
                  end else begin
                     finish_cp(acc, int'(seq_len) + 1);
                  end
               end
            end
         end
      end
   endfunction

   function automatic void check_item();
      norm_item_type want;
      if (awaited_items.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected item: kind %0d byte %02h status %0d length %0d last %0d",
                     rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8], rsp_tdata[18:11],
                     rsp_tlast);
      end else begin
         want = awaited_items.pop_front();
         if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.data ||
             rsp_tdata[10:8] !== want.st || rsp_tdata[18:11] !== want.length ||
             rsp_tdata[23:19] !== 5'd0 || rsp_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("mismatch: expected kind %0d byte %02h status %0d length %0d last %0d, ",
                      want.kind, want.data, want.st, want.length, want.last);
               $display("got kind %0d byte %02h status %0d length %0d last %0d pad %02h",
                        rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8], rsp_tdata[18:11],
                        rsp_tlast, rsp_tdata[23:19]);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_text();
         awaited_items.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_item();
         if (req_tvalid && req_tready) begin
            normalise_byte(req_tdata);
            for (int i = 0; i < burst_n; i++) begin
               if (i == burst_n - 1) burst[i].last = 1'b1;
               awaited_items.push_back(burst[i]);
            end
         end
      end
      open_count <= awaited_items.size();
      fail_count <= mismatches;
   end

endmodule

>>> sim/utf8_validate_whitespace_collapse_unit_tb.sv
// utf8_validate_whitespace_collapse_unit_tb: drives texts of valid and broken utf-8 into
// the validator with random idling on both sides and gives the verdict.
// Depends on uvwc_pkg, the top level and utf8_collapse_checker.
module utf8_validate_whitespace_collapse_unit_tb
   import uvwc_pkg::*;
();

   localparam int unsigned CAPACITY    = 256;
   localparam int unsigned SHORT_ITEMS = 44;
   localparam int unsigned IDLE_STOP   = 240;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        idle_on = 1'b1;
   int unsigned fail_count;
   int unsigned open_count;
   int unsigned cycles = 0;
   int unsigned sent_count = 0;

   utf8_validate_whitespace_collapse_unit #(.SOURCE_CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_collapse_checker #(.SOURCE_CAPACITY(CAPACITY)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("utf8_validate_whitespace_collapse_unit_tb: errors");
         $finish;
      end
   end

   // receiver stalls in bursts while idling is on
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (sent_count > IDLE_STOP) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   function automatic int natural_len(input logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   // encodes cp in exactly len bytes and sends the first upto of them
   task automatic send_cp(input logic [20:0] cp, input int len, input int upto);
      logic [7:0] enc[4];
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < upto; i++) send_byte(enc[i]);
   endtask

   task automatic send_good_cp();
      int          pick;
      int          r;
      logic [20:0] cp;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         cp = 21'($urandom_range(8'h21, 8'h7E));
      end else if (pick < 60) begin
         r = $urandom_range(0, 5);
         cp = (r == 5) ? 21'h20 : 21'(21'h09 + r);
      end else if (pick < 68) begin
         r = $urandom_range(0, 8);
         case (r)
            0: cp = 21'h85;
            1: cp = 21'hA0;
            2: cp = 21'h1680;
            3: cp = 21'(21'h2000 + $urandom_range(0, 10));
            4: cp = 21'h2028;
            5: cp = 21'h2029;
            6: cp = 21'h202F;
            7: cp = 21'h205F;
            default: cp = 21'h3000;
         endcase
      end else if (pick < 79) begin
         cp = 21'($urandom_range(21'hA0, 21'h7FF));
      end else if (pick < 90) begin
         cp = 21'($urandom_range(21'h800, 21'hFFFF));
         if (cp >= SURR_MIN && cp <= SURR_MAX) cp = cp ^ 21'h1000;
      end else begin
         cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      end
      send_cp(cp, natural_len(cp), natural_len(cp));
   endtask

   // one malformed or forbidden piece; tail_ok is low after a truncation
   task automatic send_bad(output logic tail_ok);
      int          n;
      logic [7:0]  c;
      logic [20:0] cp;
      tail_ok = 1'b1;
      case ($urandom_range(0, 7))
         0: begin
            c = 8'($urandom_range(1, 8'h1F));
            if (c >= 8'h09 && c <= 8'h0D) c = 8'h7F;
            send_byte(c);
         end
         1: begin
            if ($urandom_range(0, 1)) c = 8'($urandom_range(8'h80, 8'hC1));
            else c = 8'($urandom_range(8'hF5, 8'hFF));
            send_byte(c);
         end
         2: begin
            // overlong form
            n = $urandom_range(2, 4);
            if (n == 2) cp = 21'($urandom_range(0, 21'h7F));
            else if (n == 3) cp = 21'($urandom_range(0, 21'h7FF));
            else cp = 21'($urandom_range(0, 21'hFFFF));
            send_cp(cp, n, n);
         end
         3: send_cp(21'($urandom_range(SURR_MIN, SURR_MAX)), 3, 3);
         4: send_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4);
         5: begin
            send_byte(8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
            if ($urandom_range(0, 1)) c = 8'($urandom_range(1, 8'h7F));
            else c = 8'($urandom_range(8'hC0, 8'hFF));
            send_byte(c);
         end
         6: begin
            // c1 control other than next-line
            cp = 21'($urandom_range(C1_MIN + 1, C1_MAX));
            if (cp == 21'h85) cp = 21'h86;
            send_cp(cp, 2, 2);
         end
         default: begin
            // truncated sequence, the text ends inside it
            cp = 21'($urandom_range(21'h80, 21'h10FFFF));
            if (cp >= SURR_MIN && cp <= SURR_MAX) cp = cp ^ 21'h1000;
            n = natural_len(cp);
            send_cp(cp, n, $urandom_range(1, n - 1));
            tail_ok = 1'b0;
         end
      endcase
   endtask

   task automatic random_text();
      int   cps;
      logic broken;
      logic tail_ok;
      cps = $urandom_range(0, 12);
      broken = 1'b0;
      tail_ok = 1'b1;
      for (int j = 0; j < cps && !broken; j++) begin
         if ($urandom_range(0, 99) < 92) begin
            send_good_cp();
         end else begin
            send_bad(tail_ok);
            broken = 1'b1;
         end
      end
      // bytes after the first error give no item
      if (broken && tail_ok)
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(1, 255)));
      send_byte(8'h00);
   endtask

   initial begin : stimulus
      logic [7:0]  directed[0:23];
      int unsigned text_start;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty text, leading/trailing and inner whitespace runs, 2 and 4 byte
      // codepoints around an ideographic space, control code, bad lead, truncation
      directed = '{8'h00,
                   8'h20, 8'h41, 8'h09, 8'h0A, 8'h7E, 8'h20, 8'h00,
                   8'hC2, 8'hA9, 8'hE3, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
                   8'h01, 8'h00,
                   8'hFF, 8'h00,
                   8'hE2, 8'h00};
      for (int i = 0; i < 24; i++) send_byte(directed[i]);

      // short random texts, valid and broken
      while (sent_count < SHORT_ITEMS) random_text();

      // long text of good codepoints: the length climbs high until the byte
      // that reaches the capacity turns the text into too long
      text_start = sent_count;
      while (sent_count - text_start < CAPACITY) send_good_cp();
      send_byte(8'h00);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("utf8_validate_whitespace_collapse_unit_tb: clean");
      end else begin
         $display("utf8_validate_whitespace_collapse_unit_tb: errors");
      end
      $finish;
   end

endmodule
